// File: sv/utd_pkg.sv
// shared types, constants and character decode for the utf16 text descrambler
`default_nettype none

package utd_pkg;

    // header and body constants
    localparam logic [7:0] MARK_BYTE = 8'hfe;
    localparam logic [7:0] BOM_LO    = 8'hff;
    localparam logic [7:0] BOM_HI    = 8'hfe;
    localparam logic [7:0] MODE_MAX  = 8'd2;
    localparam logic [7:0] MODE_ZLIB = 8'd2;
    localparam logic [15:0] CTRL_LIMIT = 16'h0020;
    localparam logic [15:0] ODD_MASK   = 16'haaaa;
    localparam logic [15:0] EVEN_MASK  = 16'h5555;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_MARKER  = 3'd1;
    localparam logic [2:0] ST_BAD_MODE   = 3'd2;
    localparam logic [2:0] ST_COMPRESSED = 3'd3;
    localparam logic [2:0] ST_BAD_BOM    = 3'd4;
    localparam logic [2:0] ST_NO_DATA    = 3'd5;

    // results per input word
    localparam int MAX_RES = 5;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    typedef enum logic [2:0] {
        PH_MARK0 = 3'd0,
        PH_MARK1 = 3'd1,
        PH_MODE  = 3'd2,
        PH_BOM0  = 3'd3,
        PH_BOM1  = 3'd4,
        PH_BODY  = 3'd5,
        PH_ERR   = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic       text_mode;
        logic [7:0] low_byte;
        logic       have_low;
        logic       bom_sent;
        logic [2:0] err_code;
    } t_state;

    localparam t_state STATE_RESET = '{PH_MARK0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK};

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [2:0] status;
    } t_res;

    typedef t_res [MAX_RES-1:0] t_res_vec;

    function automatic logic [15:0] decode_char(input logic mode, input logic [15:0] ch);
        logic [15:0] r;
        if (!mode) begin
            if (ch >= CTRL_LIMIT) begin
                r = ch ^ {ch[7:1], 1'b0, 7'b0, 1'b1};
            end else begin
                r = ch;
            end
        end else begin
            r = ((ch & ODD_MASK) >> 1) | ((ch & EVEN_MASK) << 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/utd_step.sv
// next-state and result-group logic for one input word
`default_nettype none

module utd_step (
    input  var utd_pkg::t_state                 i_state,
    input  var logic [7:0]                      i_in_byte,
    input  var logic                            i_end_of_file,
    output utd_pkg::t_state                     o_state,
    output logic [utd_pkg::CNT_W-1:0]           o_cnt,
    output utd_pkg::t_res_vec                   o_res
);
    import utd_pkg::*;

    logic [15:0] ch_raw;
    logic [15:0] ch_dec;
    logic [2:0]  eof_status;

    assign ch_raw = {i_in_byte, i_state.low_byte};
    assign ch_dec = decode_char(i_state.text_mode, ch_raw);

    always_comb begin
        o_state    = i_state;
        o_cnt      = '0;
        o_res      = '0;
        eof_status = ST_OK;

        case (i_state.phase)
            PH_MARK0, PH_MARK1: begin
                if (i_in_byte == MARK_BYTE) begin
                    o_state.phase = (i_state.phase == PH_MARK0) ? PH_MARK1 : PH_MODE;
                end else begin
                    o_state.err_code = ST_NO_MARKER;
                    o_state.phase    = PH_ERR;
                end
            end
            PH_MODE: begin
                if (i_in_byte > MODE_MAX) begin
                    o_state.err_code = ST_BAD_MODE;
                    o_state.phase    = PH_ERR;
                end else begin
                    o_state.err_code  = (i_in_byte == MODE_ZLIB) ? ST_COMPRESSED : ST_OK;
                    o_state.text_mode = i_in_byte[0];
                    o_state.phase     = PH_BOM0;
                end
            end
            PH_BOM0: begin
                if (i_in_byte == BOM_LO) begin
                    o_state.phase = PH_BOM1;
                end else begin
                    o_state.err_code = ST_BAD_BOM;
                    o_state.phase    = PH_ERR;
                end
            end
            PH_BOM1: begin
                if (i_in_byte != BOM_HI) begin
                    o_state.err_code = ST_BAD_BOM;
                    o_state.phase    = PH_ERR;
                end else if (i_state.err_code == ST_COMPRESSED) begin
                    o_state.err_code = ST_COMPRESSED;
                    o_state.phase    = PH_ERR;
                end else begin
                    o_state.phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (!i_state.have_low) begin
                    o_state.low_byte = i_in_byte;
                    o_state.have_low = 1'b1;
                end else begin
                    o_state.have_low = 1'b0;
                    if (!i_state.bom_sent) begin
                        o_res[o_cnt] = '{BOM_LO, 1'b0, ST_OK};
                        o_cnt        = o_cnt + 1'b1;
                        o_res[o_cnt] = '{BOM_HI, 1'b0, ST_OK};
                        o_cnt        = o_cnt + 1'b1;
                        o_state.bom_sent = 1'b1;
                    end
                    o_res[o_cnt] = '{ch_dec[7:0], 1'b0, ST_OK};
                    o_cnt        = o_cnt + 1'b1;
                    o_res[o_cnt] = '{ch_dec[15:8], 1'b0, ST_OK};
                    o_cnt        = o_cnt + 1'b1;
                end
            end
            default: ;
        endcase

        // status from where the header got to
        case (o_state.phase)
            PH_MARK0, PH_MARK1: eof_status = ST_NO_MARKER;
            PH_MODE:            eof_status = ST_BAD_MODE;
            PH_BOM0, PH_BOM1:   eof_status = ST_BAD_BOM;
            PH_BODY:            eof_status = o_state.bom_sent ? ST_OK : ST_NO_DATA;
            default:            eof_status = o_state.err_code;
        endcase

        if (i_end_of_file) begin
            o_res[o_cnt] = '{8'h00, 1'b1, eof_status};
            o_cnt        = o_cnt + 1'b1;
            o_state      = STATE_RESET;
        end
    end

endmodule

`default_nettype wire

// File: sv/utf16_text_descrambler_top.sv
// top level of the utf16 text descrambler: header check, decode and result serializer
// a word's first result is shown in the cycle after the word is taken
// throughput: one input word per cycle while each word yields at most one result
//   and the receiver does not stall; a word yielding several results keeps the input
//   stalled until its last result is taken, as the result register drains one byte per cycle while i_stall is low
// reset: synchronous active low, returns the header tracker to the first marker byte
//   and empties the result register
`default_nettype none

module utf16_text_descrambler_top (
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    // input channel
    input  var logic       i_valid,
    output logic           o_stall,
    input  var logic [7:0] i_in_byte,
    input  var logic       i_end_of_file,
    // output channel
    output logic           o_valid,
    input  var logic       i_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_is_status,
    output logic [2:0]     o_status,
    output logic           o_last_of_run
);
    import utd_pkg::*;

    // decoder state, updated on every accepted word
    t_state r_st;
    t_state n_st;

    // result group register: up to MAX_RES results, drained one per cycle while the receiver does not stall
    t_res_vec         r_res;
    t_res_vec         n_res;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [IDX_W-1:0] r_idx;

    logic in_acc;
    logic out_acc;
    logic at_last;

    utd_step u_step (
        .i_state       (r_st),
        .i_in_byte     (i_in_byte),
        .i_end_of_file (i_end_of_file),
        .o_state       (n_st),
        .o_cnt         (n_cnt),
        .o_res         (n_res)
    );

    // output side: the group is busy while it holds results not yet taken
    assign o_valid       = (r_cnt != '0);
    assign at_last       = (CNT_W'(r_idx) == r_cnt - 1'b1);
    assign out_acc       = o_valid && !i_stall;
    assign o_out_byte    = r_res[r_idx].out_byte;
    assign o_is_status   = r_res[r_idx].is_status;
    assign o_status      = r_res[r_idx].status;
    assign o_last_of_run = at_last;

    // a new word may enter when the group is empty or its last result leaves now
    assign o_stall = o_valid && !(out_acc && at_last);
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= STATE_RESET;
            r_cnt <= '0;
            r_idx <= '0;
        end else if (in_acc) begin
            // a word with no result leaves the group empty
            r_st  <= n_st;
            r_cnt <= n_cnt;
            r_idx <= '0;
        end else if (out_acc) begin
            if (at_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    // the shown result always lies inside the group
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CNT_W'(r_idx) < r_cnt))
        else $error("result index outside the group");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RES))
        else $error("result group count too large");

    // end of file leaves the tracker reset and closes the group with a status
    a_eof_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_file) |=> (r_st == STATE_RESET))
        else $error("state not reset after end of file");

    a_eof_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_file) |=> r_res[IDX_W'(r_cnt - 1'b1)].is_status)
        else $error("end of file group does not end in a status");

    // a status result is always the last of its group
    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_status) |-> at_last)
        else $error("status result is not the last of its group");

endmodule

`default_nettype wire

// File: test/utf16_text_descrambler_top_tb.sv
// self-checking testbench for the utf16 text descrambler: byte files in, decoded bytes and status out
module utf16_text_descrambler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utd_pkg::*;

    // body modes carried by the header mode byte
    localparam logic [7:0] MODE_XOR  = 8'd0;
    localparam logic [7:0] MODE_SWAP = 8'd1;

    // about how many words the run offers
    localparam int WORD_TARGET = 260;
    // percent of cycles in which either side idles
    localparam int IDLE_PCT = 31;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES = 60;

    // one word on the input channel
    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } t_in_word;

    // one word on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [2:0] status;
        logic       last_of_run;
    } t_out_word;

    // tracks the header and body decode and holds the decoded words still to come
    class descramble_scoreboard;
        t_phase     phase;
        logic       swap_mode;
        logic [7:0] low_byte;
        logic       have_low;
        logic       bom_sent;
        logic [2:0] err_code;
        t_out_word  decoded_q[$];
        int         mismatches;
        int         checked;
        int         status_seen;

        function new();
            clear_file();
            mismatches  = 0;
            checked     = 0;
            status_seen = 0;
        endfunction

        function void clear_file();
            phase     = PH_MARK0;
            swap_mode = 1'b0;
            low_byte  = 8'h00;
            have_low  = 1'b0;
            bom_sent  = 1'b0;
            err_code  = ST_OK;
        endfunction

        function void latch_error(logic [2:0] code);
            err_code = code;
            phase    = PH_ERR;
        endfunction

        function logic [15:0] unscramble(logic [15:0] ch);
            logic [15:0] r;
            r = ch;
            if (!swap_mode) begin
                // printable characters carry a mask built from their own low byte
                if (ch >= 16'h0020)
                    r = ch ^ ((16'(ch[7:0] & 8'hfe) << 8) ^ 16'h0001);
            end else begin
                for (int i = 0; i < 16; i += 2) begin
                    r[i]     = ch[i+1];
                    r[i+1]   = ch[i];
                end
            end
            return r;
        endfunction

        function void push(logic [7:0] b, logic is_st, logic [2:0] st);
            t_out_word w;
            w.out_byte    = b;
            w.is_status   = is_st;
            w.status      = st;
            w.last_of_run = 1'b0;
            decoded_q.insert(decoded_q.size(), w);
        endfunction

        // an input word was taken by the block
        function void note_input(logic [7:0] b, logic eof);
            int          start_size;
            logic [15:0] ch;
            logic [2:0]  st;
            start_size = decoded_q.size();
            case (phase)
                PH_MARK0, PH_MARK1: begin
                    if (b == MARK_BYTE)
                        phase = (phase == PH_MARK0) ? PH_MARK1 : PH_MODE;
                    else
                        latch_error(ST_NO_MARKER);
                end
                PH_MODE: begin
                    if (b > MODE_MAX) begin
                        latch_error(ST_BAD_MODE);
                    end else begin
                        err_code  = (b == MODE_ZLIB) ? ST_COMPRESSED : ST_OK;
                        swap_mode = b[0];
                        phase     = PH_BOM0;
                    end
                end
                PH_BOM0: begin
                    if (b == BOM_LO) phase = PH_BOM1;
                    else latch_error(ST_BAD_BOM);
                end
                PH_BOM1: begin
                    if (b != BOM_HI) latch_error(ST_BAD_BOM);
                    else if (err_code == ST_COMPRESSED) latch_error(ST_COMPRESSED);
                    else phase = PH_BODY;
                end
                PH_BODY: begin
                    if (!have_low) begin
                        low_byte = b;
                        have_low = 1'b1;
                    end else begin
                        ch       = unscramble({b, low_byte});
                        have_low = 1'b0;
                        if (!bom_sent) begin
                            push(BOM_LO, 1'b0, ST_OK);
                            push(BOM_HI, 1'b0, ST_OK);
                            bom_sent = 1'b1;
                        end
                        push(ch[7:0], 1'b0, ST_OK);
                        push(ch[15:8], 1'b0, ST_OK);
                    end
                end
                default: ;
            endcase
            if (eof) begin
                case (phase)
                    PH_MARK0, PH_MARK1: st = ST_NO_MARKER;
                    PH_MODE:            st = ST_BAD_MODE;
                    PH_BOM0, PH_BOM1:   st = ST_BAD_BOM;
                    PH_BODY:            st = bom_sent ? ST_OK : ST_NO_DATA;
                    default:            st = err_code;
                endcase
                push(8'h00, 1'b1, st);
                clear_file();
            end
            if (decoded_q.size() > start_size)
                decoded_q[decoded_q.size()-1].last_of_run = 1'b1;
        endfunction

        // a word left the block
        function void check_output(t_out_word got);
            t_out_word want;
            checked++;
            if (got.is_status) status_seen++;
            if (decoded_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word byte=%h is_status=%b status=%0d last=%b",
                         $time, got.out_byte, got.is_status, got.status, got.last_of_run);
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                mismatches++;
                $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                         got.out_byte);
            end
            if (got.is_status !== want.is_status) begin
                mismatches++;
                $display("%0t: is_status expected %b actual %b", $time, want.is_status,
                         got.is_status);
            end
            if (got.status !== want.status) begin
                mismatches++;
                $display("%0t: status expected %0d actual %0d", $time, want.status,
                         got.status);
            end
            if (got.last_of_run !== want.last_of_run) begin
                mismatches++;
                $display("%0t: last_of_run expected %b actual %b", $time,
                         want.last_of_run, got.last_of_run);
            end
        endfunction
    endclass

    // clock, reset and block ports; the driven inputs are known from time zero
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_end_of_file = 1'b0;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_is_status;
    logic [2:0] o_status;
    logic       o_last_of_run;

    descramble_scoreboard sb = new();

    // file being assembled before it is sent
    t_in_word file_words[$];
    int       words_sent = 0;
    int       files_sent = 0;

    // shared between sender and receiver: no idling at all, and the long hold-off request
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    utf16_text_descrambler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_file (i_end_of_file),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_is_status   (o_is_status),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    // ---------------------------------------------------------------
    // receiver: checks every taken word, stalls at random and holds
    // off once for a long stretch so the block backs up its input
    // ---------------------------------------------------------------
    initial begin
        int        hold_left;
        bit        hold_taken;
        t_out_word got;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            // values seen here are the ones from before the edge
            if (i_rst_n && o_valid && !i_stall) begin
                got.out_byte    = o_out_byte;
                got.is_status   = o_is_status;
                got.status      = o_status;
                got.last_of_run = o_last_of_run;
                sb.check_output(got);
            end
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------
    // sender side helpers
    // ---------------------------------------------------------------

    function void add_word(logic [7:0] b, logic eof);
        t_in_word w;
        w.data = b;
        w.eof  = eof;
        file_words.insert(file_words.size(), w);
    endfunction

    // marker, mode and bom, optionally ending the file on the last bom byte
    function void add_header(logic [7:0] mode, logic eof_last);
        add_word(MARK_BYTE, 1'b0);
        add_word(MARK_BYTE, 1'b0);
        add_word(mode, 1'b0);
        add_word(BOM_LO, 1'b0);
        add_word(BOM_HI, eof_last);
    endfunction

    // body byte, biased toward small values so control characters show up
    function logic [7:0] body_byte();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 31));
        return 8'($urandom);
    endfunction

    function logic [7:0] pick_mode();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return MODE_ZLIB;
        return (r < 10) ? MODE_XOR : MODE_SWAP;
    endfunction

    // one random file: mostly well formed, some broken, truncated or noise
    function void build_random_file();
        logic [7:0] hdr [5];
        int         kind;
        int         len;
        int         pos;
        logic [7:0] mode;
        kind   = $urandom_range(0, 99);
        mode   = pick_mode();
        hdr[0] = MARK_BYTE;
        hdr[1] = MARK_BYTE;
        hdr[2] = mode;
        hdr[3] = BOM_LO;
        hdr[4] = BOM_HI;
        if (kind < 65) begin
            // mostly short bodies, now and then a longer one
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 8);
            add_header(mode, len == 0);
            for (int i = 0; i < len; i++)
                add_word(body_byte(), i == len - 1);
        end else if (kind < 80) begin
            // one header byte wrong, then a few ignored bytes
            pos = $urandom_range(0, 4);
            if (pos == 2) hdr[2] = 8'($urandom_range(3, 255));
            else hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
            len = $urandom_range(0, 4);
            for (int i = 0; i < 5; i++)
                add_word(hdr[i], (i == 4) && (len == 0));
            for (int i = 0; i < len; i++)
                add_word(8'($urandom), i == len - 1);
        end else if (kind < 90) begin
            // file ends inside the header
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                add_word(hdr[i], i == len - 1);
        end else begin
            // plain noise
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                add_word(8'($urandom), i == len - 1);
        end
    endfunction

    // drop valid for a few cycles
    task automatic idle_input(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // offer one word and wait until the block takes it
    task automatic send_word(t_in_word w);
        i_valid       <= 1'b1;
        i_in_byte     <= w.data;
        i_end_of_file <= w.eof;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(w.data, w.eof);
        words_sent++;
    endtask

    task automatic send_file();
        foreach (file_words[i]) begin
            send_word(file_words[i]);
            // each following cycle idles with the same chance
            while (!calm && $urandom_range(0, 99) < IDLE_PCT)
                idle_input(1);
        end
        file_words.delete();
        files_sent++;
    endtask

    // ---------------------------------------------------------------
    // stimulus: reset, directed files, then random files
    // ---------------------------------------------------------------
    initial begin
        int fidx;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // xor mode: control character kept, all-ones character, odd trailing byte dropped
        add_header(MODE_XOR, 1'b0);
        add_word(8'h1f, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'hff, 1'b0);
        add_word(8'hff, 1'b0);
        add_word(8'h7a, 1'b1);
        send_file();
        // swap mode, eof on the first full character: bom, two bytes and status at once
        add_header(MODE_SWAP, 1'b0);
        add_word(8'h55, 1'b0);
        add_word(8'haa, 1'b1);
        send_file();
        // mode byte out of range, following byte ignored
        add_word(MARK_BYTE, 1'b0);
        add_word(MARK_BYTE, 1'b0);
        add_word(8'hff, 1'b0);
        add_word(8'h00, 1'b1);
        send_file();
        // compressed mode flagged on the bom, eof on the same word
        add_header(MODE_ZLIB, 1'b1);
        send_file();

        fidx = 4;
        while (words_sent < WORD_TARGET) begin
            // a stretch of files with no idling on either side
            calm = (fidx >= 8 && fidx < 16);
            // long receiver hold-off inside that stretch while words keep coming
            if (fidx == 10) hold_req = 1'b1;
            // sender waits for the block to drain completely
            if (fidx == 24) begin
                i_valid <= 1'b0;
                while (sb.decoded_q.size() != 0) @(posedge i_clk);
            end
            build_random_file();
            send_file();
            fidx++;
        end
        calm = 1'b0;

        // drain, then allow a few cycles for anything stray
        i_valid <= 1'b0;
        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("run covered %0d files, %0d input words, %0d output words (%0d status)",
                 files_sent, words_sent, sb.checked, sb.status_seen);
        if (sb.mismatches == 0) begin
            $display("utf16_text_descrambler_top verification clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("utf16_text_descrambler_top verification failed");
        end
        $finish;
    end

    // safety net for a hung handshake
    initial begin
        #3ms;
        $display("timeout with %0d words still expected", sb.decoded_q.size());
        $display("utf16_text_descrambler_top verification failed");
        $finish;
    end

endmodule
